[rtl/core/ssra_pkg.sv]
`default_nettype none

package ssra_pkg;

   // field and datapath widths
   localparam int FRAC_BITS_DEF = 16;
   localparam int FACTOR_W      = 24;
   localparam int POS_W         = 32;
   localparam int RAD_W         = 31;
   localparam int FORCE_W       = 48;
   localparam int DIFF_W        = 33;
   localparam int RS_W          = 32;
   localparam int D2_W          = 64;
   localparam int SQRT_STEPS    = 32;
   localparam int REM_W         = 35;
   localparam int CNT_W         = 5;
   localparam int ADDR_W        = 3;
   localparam int DATA_W        = 32;

   // register index, taken from paddr bit 2
   localparam logic REG_FACTOR = 1'b0;

   typedef struct packed {
      logic signed [POS_W-1:0] target_x;
      logic signed [POS_W-1:0] target_y;
      logic signed [POS_W-1:0] target_z;
      logic [RAD_W-1:0]        target_radius;
      logic signed [POS_W-1:0] neighbor_x;
      logic signed [POS_W-1:0] neighbor_y;
      logic signed [POS_W-1:0] neighbor_z;
      logic [RAD_W-1:0]        neighbor_radius;
      logic                    neighbor_present;
      logic                    last_neighbor;
   } req_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_x;
      logic signed [FORCE_W-1:0] force_y;
      logic signed [FORCE_W-1:0] force_z;
   } rsp_type;

   // classified pair handed from front to back
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [DIFF_W-1:0] dz;
      logic [RS_W-1:0]          rs;
      logic [D2_W-1:0]          d2;
      logic                     hit;
      logic                     last;
   } pair_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_DIV,
      ST_RATIO,
      ST_TERM,
      ST_ACC,
      ST_SCALE,
      ST_EMIT
   } back_state_type;

endpackage

`default_nettype wire

[rtl/core/ssra_front.sv]
`default_nettype none

module ssra_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ssra_pkg::req_type req_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output ssra_pkg::pair_type     out_data
);

   localparam int DW = ssra_pkg::DIFF_W;
   localparam int RW = ssra_pkg::RS_W;
   localparam int QW = ssra_pkg::D2_W;

   logic                 advance;
   logic                 s1_valid_ff, s2_valid_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0] dx2_ff, dy2_ff, dz2_ff;
   logic [RW-1:0]        rs_ff, rs2_ff;
   logic                 present_ff, last_ff, present2_ff, last2_ff;
   logic [QW-1:0]        sqx_ff, sqy_ff, sqz_ff, rsq_ff;
   logic [RW-1:0]        ax, ay, az;
   logic [QW+1:0]        d2_sum;

   // whole pipeline moves unless its last stage is stuck
   assign advance   = !s2_valid_ff || out_ready;
   assign req_ready = advance;
   assign out_valid = s2_valid_ff;

   // magnitudes of the differences stay below 2^32
   assign ax = dx_ff[DW-1] ? RW'(-dx_ff) : RW'(dx_ff);
   assign ay = dy_ff[DW-1] ? RW'(-dy_ff) : RW'(dy_ff);
   assign az = dz_ff[DW-1] ? RW'(-dz_ff) : RW'(dz_ff);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage one: differences and radius sum
   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff      <= DW'(req_data.target_x) - DW'(req_data.neighbor_x);
         dy_ff      <= DW'(req_data.target_y) - DW'(req_data.neighbor_y);
         dz_ff      <= DW'(req_data.target_z) - DW'(req_data.neighbor_z);
         rs_ff      <= RW'(req_data.target_radius) + RW'(req_data.neighbor_radius);
         present_ff <= req_data.neighbor_present;
         last_ff    <= req_data.last_neighbor;
      end
   end

   // stage two: squares
   always_ff @(posedge clock) begin
      if (advance) begin
         sqx_ff      <= QW'(ax) * QW'(ax);
         sqy_ff      <= QW'(ay) * QW'(ay);
         sqz_ff      <= QW'(az) * QW'(az);
         rsq_ff      <= QW'(rs_ff) * QW'(rs_ff);
         dx2_ff      <= dx_ff;
         dy2_ff      <= dy_ff;
         dz2_ff      <= dz_ff;
         rs2_ff      <= rs_ff;
         present2_ff <= present_ff;
         last2_ff    <= last_ff;
      end
   end

   // overlap test on the exact squared distance
   assign d2_sum = (QW+2)'(sqx_ff) + (QW+2)'(sqy_ff) + (QW+2)'(sqz_ff);

   always_comb begin
      out_data.dx   = dx2_ff;
      out_data.dy   = dy2_ff;
      out_data.dz   = dz2_ff;
      out_data.rs   = rs2_ff;
      out_data.d2   = d2_sum[QW-1:0];
      out_data.hit  = present2_ff && (d2_sum < (QW+2)'(rsq_ff));
      out_data.last = last2_ff;
   end

endmodule

`default_nettype wire

[rtl/core/ssra_queue.sv]
`default_nettype none

module ssra_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire ssra_pkg::pair_type in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ssra_pkg::pair_type      out_data
);

   ssra_pkg::pair_type entry_ff [2];
   logic               wr_ptr_ff, rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= in_data;
   end

endmodule

`default_nettype wire

[rtl/core/ssra_back.sv]
`default_nettype none

module ssra_back #(
   parameter int FRAC_BITS = ssra_pkg::FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [ssra_pkg::FACTOR_W-1:0]    factor,
   input  wire logic                             in_valid,
   output logic                                  in_ready,
   input  wire ssra_pkg::pair_type               in_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output ssra_pkg::rsp_type                     rsp_data
);

   localparam int FW  = ssra_pkg::FORCE_W;
   localparam int DW  = ssra_pkg::DIFF_W;
   localparam int RW  = ssra_pkg::RS_W;
   localparam int MW  = ssra_pkg::REM_W;
   localparam int CW  = ssra_pkg::CNT_W;
   localparam int KW  = ssra_pkg::FACTOR_W;
   localparam int HW  = FW / 2;
   localparam int PW  = HW + KW;
   localparam int R2W = FRAC_BITS + 1;

   ssra_pkg::back_state_type state_ff, state_in;
   ssra_pkg::pair_type       entry_ff;
   logic [MW-1:0]            rem_ff, rem_in;
   logic [RW-1:0]            root_ff, root_in;
   logic [ssra_pkg::D2_W-1:0] val_ff, val_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [FRAC_BITS-1:0]     quo_ff, quo_in;
   logic [RW:0]              drem_ff, drem_in;
   logic [R2W-1:0]           r2_ff, r2_in;
   logic signed [DW-1:0]     tx_ff, ty_ff, tz_ff;
   logic signed [FW-1:0]     sx_ff, sy_ff, sz_ff;
   logic [PW-1:0]            hx_ff, hy_ff, hz_ff, lx_ff, ly_ff, lz_ff;
   logic                     rsp_valid_ff;
   ssra_pkg::rsp_type        rsp_ff;
   logic                     pop, out_free;
   logic [MW-1:0]            rem_sh, trial;
   logic [RW:0]              drem_sh;
   logic [R2W-1:0]           ratio;
   logic [2*R2W-1:0]         ratio_sq;
   logic [FW-1:0]            mx, my, mz;

   // overlap term: |d| * r2 / 2^F with the sign of d
   function automatic logic signed [DW-1:0] term_of(logic signed [DW-1:0] d,
                                                    logic [R2W-1:0] r2);
      logic [RW-1:0]     m;
      logic [RW+R2W-1:0] p;
      logic [DW-1:0]     t;
      m = d[DW-1] ? RW'(-d) : RW'(d);
      p = (RW+R2W)'(m) * (RW+R2W)'(r2);
      t = DW'(p >> FRAC_BITS);
      return d[DW-1] ? -$signed(t) : $signed(t);
   endfunction

   // saturating 48 bit add
   function automatic logic signed [FW-1:0] sat_add(logic signed [FW-1:0] a,
                                                    logic signed [DW-1:0] b);
      logic signed [FW:0] s;
      s = (FW+1)'(a) + (FW+1)'(b);
      if (s[FW] != s[FW-1]) return s[FW] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
      return s[FW-1:0];
   endfunction

   function automatic logic [FW-1:0] mag_of(logic signed [FW-1:0] s);
      return s[FW-1] ? FW'(-s) : FW'(s);
   endfunction

   // final scaling from the registered partial products
   function automatic logic signed [FW-1:0] scale_of(logic neg, logic [PW-1:0] hi,
                                                     logic [PW-1:0] lo);
      logic [FW:0] lim, r;
      lim = neg ? (FW+1)'(1) << (FW-1) : ((FW+1)'(1) << (FW-1)) - (FW+1)'(1);
      if (hi >= (PW'(1) << (FW/2 - 1 + FRAC_BITS))) begin
         r = lim;
      end else begin
         r = ((FW+1)'(hi) << (KW - FRAC_BITS)) + (FW+1)'(lo >> FRAC_BITS);
         if (r > lim) r = lim;
      end
      return neg ? -$signed(r[FW-1:0]) : $signed(r[FW-1:0]);
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = in_valid && in_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // sum magnitudes for the output scaling
   assign mx = mag_of(sx_ff);
   assign my = mag_of(sy_ff);
   assign mz = mag_of(sz_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssra_pkg::ST_IDLE: begin
            if (in_valid) begin
               if (in_data.hit) state_in = ssra_pkg::ST_SQRT;
               else if (in_data.last) state_in = ssra_pkg::ST_SCALE;
            end
         end
         ssra_pkg::ST_SQRT:  if (cnt_ff == '0) state_in = ssra_pkg::ST_DIV;
         ssra_pkg::ST_DIV:   if (cnt_ff == '0) state_in = ssra_pkg::ST_RATIO;
         ssra_pkg::ST_RATIO: state_in = ssra_pkg::ST_TERM;
         ssra_pkg::ST_TERM:  state_in = ssra_pkg::ST_ACC;
         ssra_pkg::ST_ACC: begin
            state_in = entry_ff.last ? ssra_pkg::ST_SCALE : ssra_pkg::ST_IDLE;
         end
         ssra_pkg::ST_SCALE: state_in = ssra_pkg::ST_EMIT;
         ssra_pkg::ST_EMIT:  if (out_free) state_in = ssra_pkg::ST_IDLE;
         default:            state_in = ssra_pkg::ST_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      in_ready = (state_ff == ssra_pkg::ST_IDLE);
   end

   // square root and divider steps
   assign rem_sh  = {rem_ff[MW-3:0], val_ff[ssra_pkg::D2_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign drem_sh = {drem_ff[RW-1:0], 1'b0};
   assign ratio   = (R2W'(1) << FRAC_BITS) - R2W'(quo_ff);
   assign ratio_sq = (2*R2W)'(ratio) * (2*R2W)'(ratio);

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      drem_in = drem_ff;
      r2_in   = r2_ff;
      unique case (state_ff)
         ssra_pkg::ST_IDLE: begin
            rem_in  = '0;
            root_in = '0;
            val_in  = in_data.d2;
            cnt_in  = CW'(ssra_pkg::SQRT_STEPS - 1);
         end
         ssra_pkg::ST_SQRT: begin
            val_in = val_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               drem_in = {1'b0, root_in};
               quo_in  = '0;
               cnt_in  = CW'(FRAC_BITS - 1);
            end
         end
         ssra_pkg::ST_DIV: begin
            if (drem_sh >= (RW+1)'(entry_ff.rs)) begin
               drem_in = drem_sh - (RW+1)'(entry_ff.rs);
               quo_in  = {quo_ff[FRAC_BITS-2:0], 1'b1};
            end else begin
               drem_in = drem_sh;
               quo_in  = {quo_ff[FRAC_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
         end
         ssra_pkg::ST_RATIO: r2_in = ratio_sq[FRAC_BITS +: R2W];
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssra_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         sz_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ssra_pkg::ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
            sx_ff        <= '0;
            sy_ff        <= '0;
            sz_ff        <= '0;
         end else begin
            if (rsp_ready) rsp_valid_ff <= 1'b0;
            if (state_ff == ssra_pkg::ST_ACC) begin
               sx_ff <= sat_add(sx_ff, tx_ff);
               sy_ff <= sat_add(sy_ff, ty_ff);
               sz_ff <= sat_add(sz_ff, tz_ff);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      val_ff  <= val_in;
      cnt_ff  <= cnt_in;
      quo_ff  <= quo_in;
      drem_ff <= drem_in;
      r2_ff   <= r2_in;
      if (pop) entry_ff <= in_data;
      if (state_ff == ssra_pkg::ST_TERM) begin
         tx_ff <= term_of(entry_ff.dx, r2_ff);
         ty_ff <= term_of(entry_ff.dy, r2_ff);
         tz_ff <= term_of(entry_ff.dz, r2_ff);
      end
      if (state_ff == ssra_pkg::ST_SCALE) begin
         hx_ff <= PW'(mx >> HW) * PW'(factor);
         hy_ff <= PW'(my >> HW) * PW'(factor);
         hz_ff <= PW'(mz >> HW) * PW'(factor);
         lx_ff <= PW'(mx[HW-1:0]) * PW'(factor);
         ly_ff <= PW'(my[HW-1:0]) * PW'(factor);
         lz_ff <= PW'(mz[HW-1:0]) * PW'(factor);
      end
      if (state_ff == ssra_pkg::ST_EMIT && out_free) begin
         rsp_ff.force_x <= scale_of(sx_ff[FW-1], hx_ff, lx_ff);
         rsp_ff.force_y <= scale_of(sy_ff[FW-1], hy_ff, ly_ff);
         rsp_ff.force_z <= scale_of(sz_ff[FW-1], hz_ff, lz_ff);
      end
   end

endmodule

`default_nettype wire

[rtl/core/soft_sphere_repulsion_accumulator.sv]
// a request passes the two front stages and the queue before it reaches the back
// the back takes a pair without overlap in its idle state; an overlapping pair runs through 32 root
// steps, FRAC_BITS divide steps, ratio, term and accumulate; new pairs are taken only in the idle state
// the front and a 2-entry queue keep taking requests while the back is busy, until they are full
// a response follows the scale and emit states after the last pair or a lone last request
// reset (synchronous, active high) clears the sums, valid bits and sets the factor to 1.0
`default_nettype none

module soft_sphere_repulsion_accumulator #(
   parameter int FRAC_BITS = ssra_pkg::FRAC_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire ssra_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output ssra_pkg::rsp_type                   rsp_data,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ssra_pkg::ADDR_W-1:0]    paddr,
   input  wire logic [ssra_pkg::DATA_W-1:0]    pwdata,
   output logic [ssra_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   logic [ssra_pkg::FACTOR_W-1:0] factor_ff;
   logic                          f_valid, f_ready, b_valid, b_ready;
   ssra_pkg::pair_type            f_data, b_data;

   // register file
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= ssra_pkg::FACTOR_W'(1) << FRAC_BITS;
      end else if (psel && penable && pwrite && paddr[2] == ssra_pkg::REG_FACTOR) begin
         factor_ff <= pwdata[ssra_pkg::FACTOR_W-1:0];
      end
   end
   assign prdata = (paddr[2] == ssra_pkg::REG_FACTOR) ?
                   ssra_pkg::DATA_W'(factor_ff) : '0;

   ssra_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   ssra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   ssra_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .factor    (factor_ff),
      .in_valid  (b_valid),
      .in_ready  (b_ready),
      .in_data   (b_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/ssra_checker.sv]
`default_nettype none

module ssra_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire ssra_pkg::rsp_type           rsp_data,
   input wire logic                        psel,
   input wire logic                        penable,
   input wire logic                        pwrite,
   input wire logic [ssra_pkg::ADDR_W-1:0] paddr,
   input wire logic [ssra_pkg::DATA_W-1:0] pwdata,
   input wire logic [ssra_pkg::DATA_W-1:0] prdata,
   input wire logic                        pready
);

   // port never stalls
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   // no response right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // factor reads back what was written
   a_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && !paddr[2] ##1 !paddr[2] |->
      prdata == ssra_pkg::DATA_W'($past(pwdata[ssra_pkg::FACTOR_W-1:0])))
      else $error("factor readback mismatch");

endmodule

bind soft_sphere_repulsion_accumulator ssra_checker u_ssra_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC = ssra_pkg::FRAC_BITS_DEF;
   localparam int FW = ssra_pkg::FORCE_W;
   localparam int KW = ssra_pkg::FACTOR_W;
   localparam int AW = ssra_pkg::ADDR_W;
   localparam int BW = ssra_pkg::DATA_W;
   localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
   localparam longint MIN48 = -64'sh8000_0000_0000;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam logic [AW-1:0] FACTOR_ADDR = {ssra_pkg::REG_FACTOR, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ssra_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ssra_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [BW-1:0] pwdata = '0;
   logic [BW-1:0] prdata;
   logic pready;

   // predictor state
   longint force_sum_x, force_sum_y, force_sum_z;
   logic [KW-1:0] gain;
   ssra_pkg::rsp_type pending_forces[$];
   int errors = 0;
   int forces_seen = 0;
   int requests_sent = 0;
   int overlaps_seen = 0;
   bit calm = 1'b0;
   longint cycles = 0;

   soft_sphere_repulsion_accumulator u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 6);
   endfunction

   function automatic logic [63:0] magnitude(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint add_sat48(longint a, longint b);
      longint s;
      s = a + b;
      if (s > MAX48) return MAX48;
      if (s < MIN48) return MIN48;
      return s;
   endfunction

   function automatic longint shaped_term(longint d, logic [63:0] r2);
      logic [63:0] m;
      m = (magnitude(d) * r2) >> FRAC;
      return d < 0 ? -longint'(m) : longint'(m);
   endfunction

   // add one overlapping pair to the running force
   function automatic void accumulate_overlap(ssra_pkg::req_type r);
      longint dx, dy, dz;
      logic [63:0] rs, ax, ay, az, sq, t, d2, len, q, ratio, r2;
      dx = longint'(r.target_x) - longint'(r.neighbor_x);
      dy = longint'(r.target_y) - longint'(r.neighbor_y);
      dz = longint'(r.target_z) - longint'(r.neighbor_z);
      rs = 64'(r.target_radius) + 64'(r.neighbor_radius);
      ax = magnitude(dx);
      ay = magnitude(dy);
      az = magnitude(dz);
      if (rs == 0 || ax >= rs || ay >= rs || az >= rs) return;
      sq = rs * rs;
      d2 = ax * ax;
      t = d2 + ay * ay;
      if (t < d2) return;
      d2 = t;
      t = d2 + az * az;
      if (t < d2) return;
      d2 = t;
      if (d2 >= sq) return;
      len = int_root(d2);
      q = (len << FRAC) / rs;
      ratio = (64'd1 << FRAC) - q;
      r2 = (ratio * ratio) >> FRAC;
      overlaps_seen++;
      force_sum_x = add_sat48(force_sum_x, shaped_term(dx, r2));
      force_sum_y = add_sat48(force_sum_y, shaped_term(dy, r2));
      force_sum_z = add_sat48(force_sum_z, shaped_term(dz, r2));
   endfunction

   // gain times sum, truncated toward zero, clamped to 48 bits
   function automatic logic [FW-1:0] scaled_force(longint s);
      logic [63:0] m, hi, lo, lim, r;
      m = magnitude(s);
      hi = (m >> 24) * 64'(gain);
      lo = (m & 64'hFF_FFFF) * 64'(gain);
      lim = s < 0 ? (64'd1 << 47) : (64'd1 << 47) - 1;
      if (hi >= (64'd1 << (23 + FRAC))) begin
         r = lim;
      end else begin
         r = (hi << (24 - FRAC)) + (lo >> FRAC);
         if (r > lim) r = lim;
      end
      return s < 0 ? FW'(-longint'(r)) : FW'(r);
   endfunction

   function automatic void predict(ssra_pkg::req_type r);
      ssra_pkg::rsp_type f;
      if (r.neighbor_present) accumulate_overlap(r);
      if (r.last_neighbor) begin
         f.force_x = scaled_force(force_sum_x);
         f.force_y = scaled_force(force_sum_y);
         f.force_z = scaled_force(force_sum_z);
         pending_forces.push_back(f);
         force_sum_x = 0;
         force_sum_y = 0;
         force_sum_z = 0;
      end
   endfunction

   // send one request, keep valid high afterwards for back-to-back issue
   task automatic send_request(ssra_pkg::req_type item);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      predict(item);
      requests_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_forces.size() != 0) @(posedge clock);
      // pairs without a last flag may still sit in the back
      repeat (150) @(posedge clock);
   endtask

   task automatic write_gain(logic [KW-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= FACTOR_ADDR;
      pwdata <= BW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      gain = value;
      // read back
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[KW-1:0] !== value) begin
         $error("repulsion_factor readback expected %0h actual %0h", value,
                prdata[KW-1:0]);
         errors++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   function automatic ssra_pkg::req_type pair_item(logic signed [31:0] tx,
                                                   logic signed [31:0] ty,
                                                   logic signed [31:0] tz, logic [30:0] tr,
                                                   logic signed [31:0] nx,
                                                   logic signed [31:0] ny,
                                                   logic signed [31:0] nz, logic [30:0] nr,
                                                   bit present, bit last);
      ssra_pkg::req_type r;
      r.target_x = tx; r.target_y = ty; r.target_z = tz; r.target_radius = tr;
      r.neighbor_x = nx; r.neighbor_y = ny; r.neighbor_z = nz; r.neighbor_radius = nr;
      r.neighbor_present = present;
      r.last_neighbor = last;
      return r;
   endfunction

   function automatic logic signed [31:0] jitter(logic [31:0] span);
      logic [31:0] v;
      v = $urandom_range(span);
      return $urandom_range(1) ? -signed'(v) : signed'(v);
   endfunction

   // random pair: mostly overlapping with small sizes, some far apart or raw noise
   function automatic ssra_pkg::req_type random_pair(bit last);
      ssra_pkg::req_type r;
      logic [30:0] tr, nr;
      logic [31:0] span;
      int kind;
      kind = $urandom_range(99);
      if (kind < 10) begin
         r = ssra_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom});
         r.last_neighbor = last;
         return r;
      end
      if (kind < 15) begin
         tr = 31'($urandom);
         nr = 31'($urandom);
      end else begin
         tr = 31'($urandom_range(1 << $urandom_range(20, 4)));
         nr = 31'($urandom_range(1 << $urandom_range(20, 4)));
      end
      span = (kind < 25) ? 32'(tr) + 32'(nr) + 32'd4096 : (32'(tr) + 32'(nr)) / 2;
      r.target_x = $urandom; r.target_y = $urandom; r.target_z = $urandom;
      r.target_radius = tr;
      r.neighbor_radius = nr;
      r.neighbor_x = r.target_x - jitter(span);
      r.neighbor_y = r.target_y - jitter(span);
      r.neighbor_z = r.target_z - jitter(span);
      r.neighbor_present = ($urandom_range(99) < 92);
      r.last_neighbor = last;
      return r;
   endfunction

   task automatic run_groups(int count);
      int n;
      while (count > 0) begin
         n = $urandom_range(8, 1);
         for (int k = 1; k <= n; k++) send_request(random_pair(k == n));
         count -= n;
      end
   endtask

   task automatic test_directed();
      logic [30:0] rmax;
      rmax = 31'h7FFF_FFFF;
      // empty slot that closes a target
      send_request(pair_item(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1));
      // coincident centers, zero radius sum, exact touch
      send_request(pair_item(32'h10000, 5, -7, 31'h8000, 32'h10000, 5, -7, 31'h8000, 1, 1));
      send_request(pair_item(100, 200, 300, 0, 100, 200, 300, 0, 1, 1));
      send_request(pair_item(32'h30000, 0, 0, 31'h10000, 0, 0, 0, 31'h20000, 1, 1));
      send_request(pair_item(0, 32'h30000, 0, 31'h10000, 0, 0, 0, 31'h20001, 1, 1));
      // extreme positions and radii
      send_request(pair_item(32'h7FFF_FFFF, 0, 0, rmax, 32'h8000_0000, 0, 0, rmax, 1, 1));
      send_request(pair_item(32'h4000_0000, 0, 0, rmax, 32'hC000_0000, 0, 0, rmax, 1, 0));
      send_request(pair_item(0, 32'h8000_0000, 0, rmax, 0, 32'h4000_0000, 0, rmax, 1, 0));
      send_request(pair_item(0, 0, 32'h7FFF_FFFF, rmax, 0, 0, 32'h0, rmax, 1, 1));
      send_request(pair_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, rmax,
                             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, rmax, 1, 1));
      send_request(pair_item(-32'sh1000, 32'h2000, -32'sh3000, 31'h4000, 32'h800, -32'sh900,
                             32'h700, 31'h3000, 1, 0));
      // overlapping pair flagged as an empty slot, then an empty slot that is last
      send_request(pair_item(0, 0, 0, 31'h10000, 32'h100, 0, 0, 31'h10000, 0, 0));
      send_request(pair_item(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000, 0, 1));
      // diagonal overlap in all three axes
      send_request(pair_item(32'h1234, -32'sh2345, 32'h3456, 31'h8000, -32'sh1111, 32'h2222,
                             -32'sh1333, 31'h9000, 1, 1));
      drain();
   endtask

   task automatic test_gain_settings();
      logic [KW-1:0] settings[6];
      settings = '{24'h0, 24'hFF_FFFF, 24'h1, 24'h8000, 24'h3_0000, 24'(1 << FRAC)};
      foreach (settings[i]) begin
         write_gain(settings[i]);
         run_groups(40);
         drain();
      end
      write_gain(24'($urandom));
      run_groups(40);
      drain();
   endtask

   // one long target with strong overlaps to push the output into saturation
   task automatic test_saturation();
      write_gain(24'hFF_FFFF);
      calm = 1'b1;
      for (int k = 1; k <= 900; k++)
         send_request(pair_item(32'h5555_5555, 32'h100, -32'sh100, 31'h7FFF_FFFF, 0, 0, 0,
                                31'h7FFF_FFFF, 1, k == 900));
      calm = 1'b0;
      drain();
      write_gain(24'(1 << FRAC));
   endtask

   task automatic test_random_stream();
      write_gain(24'($urandom_range(24'h4_0000)));
      calm = 1'b1;
      run_groups(150);
      calm = 1'b0;
      run_groups(250);
      drain();
   endtask

   // result stall at random
   always @(posedge clock) rsp_ready <= !take_break();

   // compare each response against the oldest prediction
   always @(posedge clock) begin
      ssra_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         forces_seen++;
         if (pending_forces.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            errors++;
         end else begin
            want = pending_forces.pop_front();
            if (rsp_data.force_x !== want.force_x) begin
               $error("force_x expected %0d actual %0d", want.force_x, rsp_data.force_x);
               errors++;
            end
            if (rsp_data.force_y !== want.force_y) begin
               $error("force_y expected %0d actual %0d", want.force_y, rsp_data.force_y);
               errors++;
            end
            if (rsp_data.force_z !== want.force_z) begin
               $error("force_z expected %0d actual %0d", want.force_z, rsp_data.force_z);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      force_sum_x = 0;
      force_sum_y = 0;
      force_sum_z = 0;
      gain = 24'(1 << FRAC);
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_gain_settings();
      test_saturation();
      test_random_stream();
      $display("sent %0d requests, %0d overlapping pairs, %0d forces checked",
               requests_sent, overlaps_seen, forces_seen);
      $display("covered gain extremes, empty slots, touching pairs and output saturation");
      if (errors == 0 && pending_forces.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ssra_pkg.sv
rtl/core/ssra_front.sv
rtl/core/ssra_queue.sv
rtl/core/ssra_back.sv
rtl/core/soft_sphere_repulsion_accumulator.sv
rtl/core/ssra_checker.sv
tb/sv/testbench.sv
